// File: sv/kbsnl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsnl_pkg
// Shared types and constants for the keyboard biphase serializer and NMI
// latch block: function codes, item and result records, port bit positions.
// ----------------------------------------------------------------------------
package kbsnl_pkg;

    typedef enum logic [2:0] {
        FUNC_SCAN      = 3'd0,
        FUNC_TICK      = 3'd1,
        FUNC_NMI_READ  = 3'd2,
        FUNC_NMI_WRITE = 3'd3,
        FUNC_PORTB_WR  = 3'd4,
        FUNC_PORTC_RD  = 3'd5,
        FUNC_TIMER2    = 3'd6
    } t_func;

    localparam int unsigned WORD_W  = 20;
    localparam int unsigned TICKS_W = 6;

    // half-bit ticks in one keyboard transfer
    localparam logic [TICKS_W-1:0] TRANSFER_TICKS = TICKS_W'(20 + 22);

    localparam logic [7:0] NMI_EN_BYTE = 8'h80;

    // port B bit positions
    localparam int unsigned PB_GATE_BIT    = 0;
    localparam int unsigned PB_SPEAKER_BIT = 1;
    localparam int unsigned PB_MOTOR_BIT   = 3;

    typedef struct packed {
        t_func      func;
        logic [7:0] data;
        logic       level;
        logic       tape_nonnegative;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_line;
        logic       serial_out;
        logic       speaker_level;
        logic       timer2_gate;
        logic       cassette_motor_on;
    } t_result;

endpackage : kbsnl_pkg
`default_nettype wire

// File: sv/kbsnl_word.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsnl_word
// Biphase word builder: start pair, eight data bit pairs and a parity pair,
// least significant pair first.
// ----------------------------------------------------------------------------
module kbsnl_word (
    input  wire logic [7:0]                   i_code,
    output logic      [kbsnl_pkg::WORD_W-1:0] o_word
);

    logic w_parity;

    assign w_parity = ^i_code;

    always_comb begin
        o_word       = '0;
        o_word[1:0]  = 2'b01;
        // a one is sent as 01, a zero as 10
        for (int i = 0; i < 8; i++) begin
            o_word[2*i+2] = i_code[i];
            o_word[2*i+3] = ~i_code[i];
        end
        o_word[18] = w_parity;
        o_word[19] = ~w_parity;
    end

endmodule : kbsnl_word
`default_nettype wire

// File: sv/kbsnl_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsnl_core
// Architectural state of the block and the single-pass update for one item.
// Produces the result of the item presented on i_item from the next state.
// ----------------------------------------------------------------------------
module kbsnl_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire kbsnl_pkg::t_item  i_item,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    output kbsnl_pkg::t_result     o_result
);

    logic [kbsnl_pkg::WORD_W-1:0]  r_word,  n_word;
    logic [kbsnl_pkg::TICKS_W-1:0] r_ticks, n_ticks;
    logic                          r_busy,  n_busy;
    logic                          r_latch, n_latch;
    logic                          r_nmi_en, n_nmi_en;
    logic                          r_nmi,   n_nmi;
    logic [7:0]                    r_port_b, n_port_b;
    logic                          r_t2,    n_t2;
    logic                          r_spk,   n_spk;
    logic                          r_mem64;

    logic [kbsnl_pkg::WORD_W-1:0]  w_built;
    logic [7:0]                    w_port_c;
    logic [7:0]                    w_rd;

    kbsnl_word u_word (
        .i_code (i_item.data),
        .o_word (w_built)
    );

    // port C snapshot, taken from the state before the item
    always_comb begin
        w_port_c    = 8'h00;
        w_port_c[6] = r_word[0];
        w_port_c[5] = r_t2;
        if (!r_port_b[kbsnl_pkg::PB_MOTOR_BIT]) begin
            w_port_c[4] = i_item.tape_nonnegative;
        end else if (r_port_b[kbsnl_pkg::PB_GATE_BIT]) begin
            w_port_c[4] = r_t2;
        end else begin
            w_port_c[4] = 1'b1;
        end
        w_port_c[3] = ~r_mem64;
        w_port_c[1] = 1'b1;
        w_port_c[0] = r_latch;
    end

    always_comb begin
        n_word   = r_word;
        n_ticks  = r_ticks;
        n_busy   = r_busy;
        n_latch  = r_latch;
        n_nmi_en = r_nmi_en;
        n_nmi    = r_nmi;
        n_port_b = r_port_b;
        n_t2     = r_t2;
        n_spk    = r_spk;
        w_rd     = 8'h00;
        case (i_item.func)
            kbsnl_pkg::FUNC_SCAN: begin
                if (i_item.data != 8'h00) begin
                    n_latch = 1'b1;
                    // a code that arrives mid-transfer only sets the latch
                    if (!r_busy) begin
                        n_word  = w_built;
                        n_ticks = kbsnl_pkg::TRANSFER_TICKS;
                        n_busy  = 1'b1;
                        n_nmi   = r_nmi_en;
                    end
                end
            end
            kbsnl_pkg::FUNC_TICK: begin
                if (r_busy) begin
                    n_word  = r_word >> 1;
                    n_ticks = r_ticks - 1'b1;
                    if (r_ticks == kbsnl_pkg::TICKS_W'(1)) begin
                        n_busy = 1'b0;
                    end
                end
            end
            kbsnl_pkg::FUNC_NMI_READ: begin
                n_latch = 1'b0;
                n_nmi   = 1'b0;
                w_rd    = r_nmi_en ? kbsnl_pkg::NMI_EN_BYTE : 8'h00;
            end
            kbsnl_pkg::FUNC_NMI_WRITE: begin
                n_nmi_en = i_item.data[7];
                n_nmi    = i_item.data[7] & r_latch;
            end
            kbsnl_pkg::FUNC_PORTB_WR: begin
                n_port_b = i_item.data;
                n_spk    = i_item.data[kbsnl_pkg::PB_SPEAKER_BIT];
            end
            kbsnl_pkg::FUNC_PORTC_RD: begin
                w_rd = w_port_c;
            end
            kbsnl_pkg::FUNC_TIMER2: begin
                n_t2 = i_item.level;
            end
            default: begin
                w_rd = 8'h00;
            end
        endcase
    end

    always_comb begin
        o_result.read_data         = w_rd;
        o_result.nmi_line          = n_nmi;
        o_result.serial_out        = n_word[0];
        o_result.speaker_level     = n_spk & n_t2;
        o_result.timer2_gate       = n_port_b[kbsnl_pkg::PB_GATE_BIT];
        o_result.cassette_motor_on = ~n_port_b[kbsnl_pkg::PB_MOTOR_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word   <= '0;
            r_ticks  <= '0;
            r_busy   <= 1'b0;
            r_latch  <= 1'b0;
            r_nmi_en <= 1'b1;
            r_nmi    <= 1'b0;
            r_port_b <= 8'h00;
            r_t2     <= 1'b1;
            r_spk    <= 1'b0;
        end else if (i_fire) begin
            r_word   <= n_word;
            r_ticks  <= n_ticks;
            r_busy   <= n_busy;
            r_latch  <= n_latch;
            r_nmi_en <= n_nmi_en;
            r_nmi    <= n_nmi;
            r_port_b <= n_port_b;
            r_t2     <= n_t2;
            r_spk    <= n_spk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem64 <= 1'b1;
        end else if (i_cfg_we) begin
            r_mem64 <= i_cfg_data;
        end
    end

endmodule : kbsnl_core
`default_nettype wire

// File: sv/keyboard_biphase_serializer_nmi_latch_unit.sv
// Path: an accepted item waits in the input register, then passes through the single
// state-update pass into the result register when that register can advance.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset (synchronous, active low) empties both registers and returns the state
// to its initial values; the memory size register resets to one.
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_biphase_serializer_nmi_latch_unit
// Top level: input register, state-update core and result register.
// ----------------------------------------------------------------------------
module keyboard_biphase_serializer_nmi_latch_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_func,
    input  wire logic [7:0] i_data,
    input  wire logic       i_level,
    input  wire logic       i_tape_nonnegative,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_read_data,
    output logic            o_nmi_line,
    output logic            o_serial_out,
    output logic            o_speaker_level,
    output logic            o_timer2_gate,
    output logic            o_cassette_motor_on,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data
);

    kbsnl_pkg::t_item   r_in;
    logic               r_in_valid;
    kbsnl_pkg::t_result r_out;
    logic               r_out_valid;
    kbsnl_pkg::t_result w_result;
    logic               w_adv;
    logic               w_fire;

    // the pipe moves when the result slot is free or being drained
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.func             <= kbsnl_pkg::t_func'(i_func);
            r_in.data             <= i_data;
            r_in.level            <= i_level;
            r_in.tape_nonnegative <= i_tape_nonnegative;
        end
    end

    kbsnl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_out.read_data;
    assign o_nmi_line          = r_out.nmi_line;
    assign o_serial_out        = r_out.serial_out;
    assign o_speaker_level     = r_out.speaker_level;
    assign o_timer2_gate       = r_out.timer2_gate;
    assign o_cassette_motor_on = r_out.cassette_motor_on;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_in_valid) |-> !o_in_ready)
        else $error("input accepted while both registers are held");

    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed item did not reach the result register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("registers not empty after reset");

    a_nmi_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.func == kbsnl_pkg::FUNC_NMI_READ) |=> !o_nmi_line)
        else $error("NMI line still high after an NMI port read");

endmodule : keyboard_biphase_serializer_nmi_latch_unit
`default_nettype wire

// File: verif/kbsnl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsnl_checker
// Watches the item, result and memory-size channels of the keyboard biphase
// serializer. Keeps its own copy of the keyboard, NMI and port state, works out
// the result of every accepted item and compares each accepted result with the
// oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module kbsnl_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [2:0] i_func,
    input  wire logic [7:0] i_data,
    input  wire logic       i_level,
    input  wire logic       i_tape_nonnegative,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_read_data,
    input  wire logic       i_nmi_line,
    input  wire logic       i_serial_out,
    input  wire logic       i_speaker_level,
    input  wire logic       i_timer2_gate,
    input  wire logic       i_cassette_motor_on,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic       i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);

    // port C bit positions
    localparam int unsigned PC_LATCH_BIT  = 0;
    localparam int unsigned PC_FLOPPY_BIT = 2;
    localparam int unsigned PC_MEM_BIT    = 3;
    localparam int unsigned PC_TAPE_BIT   = 4;
    localparam int unsigned PC_OUT2_BIT   = 5;
    localparam int unsigned PC_KEYIN_BIT  = 6;
    localparam int unsigned PC_CABLE_BIT  = 7;

    localparam logic [1:0] PAIR_ONE  = 2'b01;
    localparam logic [1:0] PAIR_ZERO = 2'b10;

    logic                          mem_over_64k;
    logic [kbsnl_pkg::WORD_W-1:0]  shift_word;
    logic [kbsnl_pkg::TICKS_W-1:0] ticks_left;
    logic                          busy;
    logic                          key_latch;
    logic                          nmi_enable;
    logic                          nmi_out;
    logic [7:0]                    port_b;
    logic                          timer2_out;
    logic                          speaker_data;

    kbsnl_pkg::t_result keyboard_port_results[$];
    int                 fails = 0;

    // Update the keyboard/NMI/port state for one item and queue its result.
    task automatic apply_keyboard_event(input logic [2:0] func, input logic [7:0] data,
                                        input logic level, input logic tape);
        kbsnl_pkg::t_result           res;
        logic [kbsnl_pkg::WORD_W-1:0] word;
        logic [7:0]                   pc;
        int                           i;
        res = '0;
        case (func)
            kbsnl_pkg::FUNC_SCAN: begin
                if (data != 8'd0) begin
                    key_latch = 1'b1;
                    // a code arriving mid-transfer only marks the latch
                    if (!busy) begin
                        word = '0;
                        word[1:0] = PAIR_ONE;
                        for (i = 0; i < 8; i++)
                            word[2 + 2 * i +: 2] = data[i] ? PAIR_ONE : PAIR_ZERO;
                        word[19:18] = (^data) ? PAIR_ONE : PAIR_ZERO;
                        shift_word = word;
                        ticks_left = kbsnl_pkg::TRANSFER_TICKS;
                        busy       = 1'b1;
                        nmi_out    = nmi_enable & key_latch;
                    end
                end
            end
            kbsnl_pkg::FUNC_TICK: begin
                if (busy) begin
                    shift_word = shift_word >> 1;
                    ticks_left = ticks_left - 1'b1;
                    if (ticks_left == '0)
                        busy = 1'b0;
                end
            end
            kbsnl_pkg::FUNC_NMI_READ: begin
                key_latch     = 1'b0;
                nmi_out       = 1'b0;
                res.read_data = nmi_enable ? kbsnl_pkg::NMI_EN_BYTE : 8'h00;
            end
            kbsnl_pkg::FUNC_NMI_WRITE: begin
                nmi_enable = (data & kbsnl_pkg::NMI_EN_BYTE) != 8'h00;
                nmi_out    = nmi_enable & key_latch;
            end
            kbsnl_pkg::FUNC_PORTB_WR: begin
                port_b       = data;
                speaker_data = data[kbsnl_pkg::PB_SPEAKER_BIT];
            end
            kbsnl_pkg::FUNC_PORTC_RD: begin
                pc = 8'hFF;
                pc[PC_CABLE_BIT]  = 1'b0;
                pc[PC_FLOPPY_BIT] = 1'b0;
                pc[PC_MEM_BIT]    = !mem_over_64k;
                pc[PC_LATCH_BIT]  = key_latch;
                if (!port_b[kbsnl_pkg::PB_MOTOR_BIT])
                    pc[PC_TAPE_BIT] = tape;
                else if (port_b[kbsnl_pkg::PB_GATE_BIT])
                    pc[PC_TAPE_BIT] = timer2_out;
                pc[PC_OUT2_BIT]  = timer2_out;
                pc[PC_KEYIN_BIT] = shift_word[0];
                res.read_data    = pc;
            end
            kbsnl_pkg::FUNC_TIMER2: begin
                timer2_out = level;
            end
            default: ;
        endcase
        res.nmi_line          = nmi_out;
        res.serial_out        = shift_word[0];
        res.speaker_level     = speaker_data & timer2_out;
        res.timer2_gate       = port_b[kbsnl_pkg::PB_GATE_BIT];
        res.cassette_motor_on = !port_b[kbsnl_pkg::PB_MOTOR_BIT];
        keyboard_port_results.push_back(res);
    endtask

    function automatic int field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        kbsnl_pkg::t_result want;
        if (!i_rst_n) begin
            mem_over_64k = 1'b1;
            shift_word   = '0;
            ticks_left   = '0;
            busy         = 1'b0;
            key_latch    = 1'b0;
            nmi_enable   = 1'b1;
            nmi_out      = 1'b0;
            port_b       = '0;
            timer2_out   = 1'b1;
            speaker_data = 1'b0;
            keyboard_port_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (keyboard_port_results.size() == 0) begin
                    $error("result transfer with no result outstanding");
                    fails++;
                end else begin
                    want = keyboard_port_results.pop_front();
                    fails += field_differs("read_data", want.read_data, i_read_data);
                    fails += field_differs("nmi_line", 8'(want.nmi_line), 8'(i_nmi_line));
                    fails += field_differs("serial_out", 8'(want.serial_out),
                                           8'(i_serial_out));
                    fails += field_differs("speaker_level", 8'(want.speaker_level),
                                           8'(i_speaker_level));
                    fails += field_differs("timer2_gate", 8'(want.timer2_gate),
                                           8'(i_timer2_gate));
                    fails += field_differs("cassette_motor_on", 8'(want.cassette_motor_on),
                                           8'(i_cassette_motor_on));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                mem_over_64k = i_cfg_data;
            if (i_in_valid && i_in_ready)
                apply_keyboard_event(i_func, i_data, i_level, i_tape_nonnegative);
        end
        o_fail_count <= fails;
        o_pending    <= keyboard_port_results.size();
    end

endmodule : kbsnl_checker

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyboard biphase serializer with NMI latch.
// A short directed run covers every function code and the corner cases, then
// random key transfers (scan code, ticks, port traffic in between) and noise
// run under three pacing modes, with the memory size flag changed between them.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         SETTLE_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [2:0] i_func = '0;
    logic [7:0] i_data = '0;
    logic       i_level = 1'b0;
    logic       i_tape_nonnegative = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data = 1'b0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_read_data;
    logic       o_nmi_line;
    logic       o_serial_out;
    logic       o_speaker_level;
    logic       o_timer2_gate;
    logic       o_cassette_motor_on;
    logic       o_cfg_ready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int item_count = 0;
    int transfer_count = 0;
    int stall_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    keyboard_biphase_serializer_nmi_latch_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_data              (i_data),
        .i_level             (i_level),
        .i_tape_nonnegative  (i_tape_nonnegative),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_read_data         (o_read_data),
        .o_nmi_line          (o_nmi_line),
        .o_serial_out        (o_serial_out),
        .o_speaker_level     (o_speaker_level),
        .o_timer2_gate       (o_timer2_gate),
        .o_cassette_motor_on (o_cassette_motor_on),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    kbsnl_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_data              (i_data),
        .i_level             (i_level),
        .i_tape_nonnegative  (i_tape_nonnegative),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_read_data         (o_read_data),
        .i_nmi_line          (o_nmi_line),
        .i_serial_out        (o_serial_out),
        .i_speaker_level     (o_speaker_level),
        .i_timer2_gate       (o_timer2_gate),
        .i_cassette_motor_on (o_cassette_motor_on),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Give up when no channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Hold valid high from one item to the next unless a gap is drawn.
    task automatic send_item(input logic [2:0] func, input logic [7:0] data,
                             input logic level, input logic tape);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_func             <= func;
        i_data             <= data;
        i_level            <= level;
        i_tape_nonnegative <= tape;
        do @(posedge i_clk); while (!o_in_ready);
        item_count++;
    endtask

    task automatic send_random(input logic [2:0] func);
        send_item(func, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // One scan code followed by its half-bit ticks, port traffic mixed in.
    task automatic key_transfer(input bit cut_short);
        int n_ticks;
        int k;
        n_ticks = cut_short ? $urandom_range(0, int'(kbsnl_pkg::TRANSFER_TICKS) - 1)
                            : $urandom_range(int'(kbsnl_pkg::TRANSFER_TICKS),
                                             int'(kbsnl_pkg::TRANSFER_TICKS) + 3);
        send_item(kbsnl_pkg::FUNC_SCAN, 8'($urandom_range(1, 255)), 1'($urandom),
                  1'($urandom));
        for (k = 0; k < n_ticks; k++) begin
            if ($urandom_range(99) < 25) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: send_random(kbsnl_pkg::FUNC_PORTC_RD);
                    4:          send_random(kbsnl_pkg::FUNC_NMI_READ);
                    5:          send_random(kbsnl_pkg::FUNC_SCAN);
                    6:          send_random(kbsnl_pkg::FUNC_NMI_WRITE);
                    7:          send_random(kbsnl_pkg::FUNC_PORTB_WR);
                    8:          send_random(kbsnl_pkg::FUNC_TIMER2);
                    default:    send_random(FUNC_UNUSED);
                endcase
            end
            send_random(kbsnl_pkg::FUNC_TICK);
        end
        if ($urandom_range(99) < 60)
            send_random(kbsnl_pkg::FUNC_NMI_READ);
        transfer_count++;
    endtask

    task automatic random_items(input int n);
        int target;
        int r;
        target = item_count + n;
        while (item_count < target) begin
            r = $urandom_range(99);
            if (r < 60)
                key_transfer(1'b0);
            else if (r < 75)
                key_transfer(1'b1);
            else
                send_random(3'($urandom_range(7)));
        end
    endtask

    // Drop valid and wait for every outstanding result to come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mem_size(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases, no pacing gaps
        send_item(kbsnl_pkg::FUNC_PORTC_RD,  8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTC_RD,  8'h00, 1'b0, 1'b1);
        send_item(kbsnl_pkg::FUNC_TICK,      8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_SCAN,      8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_NMI_READ,  8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_SCAN,      8'hFF, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_TICK,      8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_TICK,      8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_SCAN,      8'h80, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTC_RD,  8'h00, 1'b0, 1'b1);
        send_item(kbsnl_pkg::FUNC_NMI_READ,  8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_NMI_WRITE, 8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_NMI_WRITE, 8'h7F, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_NMI_READ,  8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_NMI_WRITE, 8'h80, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTB_WR,  8'hFF, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_TIMER2,    8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTC_RD,  8'h00, 1'b0, 1'b1);
        send_item(kbsnl_pkg::FUNC_TIMER2,    8'h00, 1'b1, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTC_RD,  8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTB_WR,  8'h08, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTC_RD,  8'h00, 1'b0, 1'b0);
        send_item(kbsnl_pkg::FUNC_PORTB_WR,  8'h00, 1'b0, 1'b0);
        send_item(FUNC_UNUSED,               8'hFF, 1'b1, 1'b1);
        drain();

        write_mem_size(1'b0);
        send_idle_pct = 29;
        recv_idle_pct = 61;
        random_items(430);
        drain();

        write_mem_size(1'b1);
        send_idle_pct = 61;
        recv_idle_pct = 29;
        random_items(430);
        drain();

        write_mem_size(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(430);
        drain();

        $display("Run covered %0d items, among them %0d scan code transfers with ticks,",
                 item_count, transfer_count);
        $display("under three pacing modes with the memory size flag at both values.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule : tb_top
